// File: hdl/integer_array_sorter_assert.svh
`ifndef INTEGER_ARRAY_SORTER_ASSERT_SVH
`define INTEGER_ARRAY_SORTER_ASSERT_SVH

// check a property on every rising edge outside reset
`define ISRT_ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("integer_array_sorter assertion failed");

// check that a condition never holds outside reset
`define ISRT_ASSERT_NEVER(label, cond) \
  `ISRT_ASSERT_PROP(label, !(cond))

`endif

// File: hdl/isrt_pkg.sv
package isrt_pkg;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic last_one;
  } status_t;

endpackage

// File: hdl/isrt_datapath.sv
module isrt_datapath #(
  parameter int DEPTH = 64,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  isrt_pkg::cmd_t      cmd,
  input  logic signed [31:0]  value,
  output isrt_pkg::status_t   status,
  output logic signed [31:0]  sorted_value,
  output logic                last_out,
  output logic                overflow
);

  logic signed [31:0] store [DEPTH];
  logic signed [31:0] prev_val [DEPTH];
  logic signed [31:0] next_val [DEPTH];
  logic [DEPTH-1:0]   greater;
  logic [DEPTH-1:0]   shift_up;
  logic [DEPTH-1:0]   write_en;
  logic [CW-1:0]      count;
  logic               dropped;
  logic               full;
  logic               last_one;

  assign full     = (count == CW'(DEPTH));
  assign last_one = (count == CW'(1));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);

    assign greater[i]  = (IDX < count) && (store[i] > value);
    assign write_en[i] = greater[i] || (IDX == count);

    if (i == 0) begin : g_first
      assign prev_val[i] = value;
      assign shift_up[i] = 1'b0;
    end else begin : g_rest
      assign prev_val[i] = store[i-1];
      assign shift_up[i] = greater[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign next_val[i] = store[i];
    end else begin : g_below
      assign next_val[i] = store[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.insert && !full) begin
        if (write_en[i]) begin
          store[i] <= shift_up[i] ? prev_val[i] : value;
        end
      end else if (cmd.pop) begin
        store[i] <= next_val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.insert) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + CW'(1);
      end
    end else if (cmd.pop) begin
      count <= count - CW'(1);
      if (last_one) begin
        dropped <= 1'b0;
      end
    end
  end

  assign status.last_one = last_one;
  assign sorted_value    = store[0];
  assign last_out        = last_one;
  assign overflow        = dropped;

endmodule

// File: hdl/isrt_controller.sv
module isrt_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tlast,
  input  logic               m_tready,
  input  isrt_pkg::status_t  status,
  output logic               s_tready,
  output logic               m_tvalid,
  output isrt_pkg::cmd_t     cmd
);

  isrt_pkg::state_t state;
  isrt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isrt_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    cmd.insert = 1'b0;
    cmd.pop    = 1'b0;
    case (state)
      isrt_pkg::ST_LOAD: begin
        s_tready   = 1'b1;
        cmd.insert = s_tvalid;
        if (s_tvalid && s_tlast) begin
          state_next = isrt_pkg::ST_DRAIN;
        end
      end
      isrt_pkg::ST_DRAIN: begin
        m_tvalid = 1'b1;
        cmd.pop  = m_tready;
        if (m_tready && status.last_one) begin
          state_next = isrt_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = isrt_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

// File: hdl/integer_array_sorter.sv
// Streaming sorter for signed 32-bit integers. Load a set one beat per cycle on
// the slave side; the beat with tlast ends the set. Each beat is placed in order
// in a chain of DEPTH compare-and-shift cells in the cycle it is accepted, so
// loading runs at one beat per cycle. After the last beat the N stored values
// leave in ascending order on the master side, one per cycle while m_tready is
// high, by shifting the chain down; s_tready is low while they drain. The
// largest value carries tlast. Beats beyond DEPTH are dropped, and tuser is 1
// on every result of a set that lost any.
module integer_array_sorter #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic signed [31:0] s_tdata,   // [31:0] value
  input  logic               s_tlast,   // last_in
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic signed [31:0] m_tdata,   // [31:0] sorted_value
  output logic               m_tlast,   // last_out
  output logic               m_tuser    // [0] overflow
);

  isrt_pkg::cmd_t    cmd;
  isrt_pkg::status_t status;

  isrt_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .m_tready (m_tready),
    .status   (status),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  isrt_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (s_tdata),
    .status       (status),
    .sorted_value (m_tdata),
    .last_out     (m_tlast),
    .overflow     (m_tuser)
  );

endmodule

// File: hdl/isrt_checker.sv
`include "integer_array_sorter_assert.svh"

module isrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  `ISRT_ASSERT_NEVER(a_load_drain_excl, s_tready && m_tvalid)
  `ISRT_ASSERT_PROP(a_end_starts_drain, s_tvalid && s_tready && s_tlast |=> m_tvalid)
  `ISRT_ASSERT_PROP(a_drain_ends_load, m_tvalid && m_tready && m_tlast |=> s_tready)
  `ISRT_ASSERT_PROP(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

endmodule

bind integer_array_sorter isrt_checker u_isrt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// File: bench/integer_array_sorter_test.sv
module integer_array_sorter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
    logic               ovf;
  } sorted_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic signed [31:0] s_tdata = '0;   // [31:0] value
  logic               s_tlast = 1'b0; // last_in
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic signed [31:0] m_tdata;        // [31:0] sorted_value
  logic               m_tlast;        // last_out
  logic               m_tuser;        // [0] overflow

  logic signed [31:0] held_values [DEPTH];
  int                 held_count = 0;
  logic               dropped = 1'b0;
  sorted_beat_t       sorted_due [$];
  sorted_beat_t       oldest;

  int  errors = 0;
  int  beats_in = 0;
  int  results_seen = 0;
  int  sets_seen = 0;
  int  sets_dropped = 0;
  int  stall_request = 0;
  bit  quiet = 1'b0;

  integer_array_sorter #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void insert_element(logic signed [31:0] v, logic last);
    int k;
    sorted_beat_t b;
    if (held_count < DEPTH) begin
      k = held_count;
      while (k > 0 && held_values[k - 1] > v) begin
        held_values[k] = held_values[k - 1];
        k--;
      end
      held_values[k] = v;
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      for (int i = 0; i < held_count; i++) begin
        b.value = held_values[i];
        b.last  = (i == held_count - 1);
        b.ovf   = dropped;
        sorted_due.push_back(b);
      end
      sets_seen++;
      if (dropped) begin
        sets_dropped++;
      end
      held_count = 0;
      dropped = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      beats_in++;
      insert_element(s_tdata, s_tlast);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (sorted_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d last %0b overflow %0b",
                 $time, m_tdata, m_tlast, m_tuser);
        errors++;
      end else begin
        oldest = sorted_due.pop_front();
        if (m_tdata !== oldest.value) begin
          $display("%0t: sorted_value expected %0d got %0d", $time, oldest.value, m_tdata);
          errors++;
        end
        if (m_tlast !== oldest.last) begin
          $display("%0t: last_out expected %0b got %0b", $time, oldest.last, m_tlast);
          errors++;
        end
        if (m_tuser !== oldest.ovf) begin
          $display("%0t: overflow expected %0b got %0b", $time, oldest.ovf, m_tuser);
          errors++;
        end
      end
    end
  end

  // receiver: random backpressure, or a counted hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (stall_request > 0) begin
        n = stall_request;
        stall_request = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        m_tready <= quiet || ($urandom_range(99) >= 26);
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return $urandom_range(1) ? 32'sd0 : -32'sd1;
      3, 4: return $signed($urandom_range(15)) - 32'sd8;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic send_beat(input logic signed [31:0] v, input logic last);
    while (!quiet && $urandom_range(99) < 26) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_values(input logic signed [31:0] vals [$]);
    foreach (vals[i]) begin
      send_beat(vals[i], i == vals.size() - 1);
    end
  endtask

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) begin
      send_beat(pick_value(), i == n - 1);
    end
  endtask

  task automatic test_extremes();
    logic signed [31:0] vals [$];
    vals = '{MOST_POS, MOST_NEG, 32'sd0, -32'sd1, 32'sd1, MOST_NEG + 1, MOST_POS - 1};
    send_values(vals);
    vals = '{MOST_NEG};
    send_values(vals);
    vals = '{MOST_POS};
    send_values(vals);
    vals = '{32'sd5, -32'sd5, 32'sd5, 32'sd5, -32'sd5, 32'sd0};
    send_values(vals);
    vals = '{32'sd3, 32'sd2, 32'sd1, 32'sd0};
    send_values(vals);
  endtask

  task automatic test_store_full();
    send_set(DEPTH);
    send_set(DEPTH + 3);
    send_set(3);
  endtask

  task automatic test_output_stall();
    stall_request = 400;
    send_set(DEPTH);
    send_set(8);
  endtask

  task automatic test_random_sets();
    int sent;
    int n;
    int pick;
    sent = 0;
    while (sent < 155) begin
      quiet = (sent >= 40 && sent < 110);
      pick = $urandom_range(99);
      if (pick < 85) begin
        n = $urandom_range(12, 1);
      end else if (pick < 95) begin
        n = $urandom_range(DEPTH, 13);
      end else begin
        n = $urandom_range(DEPTH + 6, DEPTH + 1);
      end
      send_set(n);
      sent += n;
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_store_full();
    test_output_stall();
    test_random_sets();
    s_tvalid <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (DEPTH + 20) @(posedge clk);
    $display("%0d beats in %0d sets (%0d with dropped beats), %0d sorted results checked",
             beats_in, sets_seen, sets_dropped, results_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still due", sorted_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/isrt_pkg.sv
hdl/isrt_datapath.sv
hdl/isrt_controller.sv
hdl/integer_array_sorter.sv
hdl/isrt_checker.sv
bench/integer_array_sorter_test.sv
